// File: src/keyed_rssi_moving_average_cache_assert.svh
// Assertion macros for the keyed signal-strength averaging cache.
`ifndef KEYED_RSSI_MOVING_AVERAGE_CACHE_ASSERT_SVH
`define KEYED_RSSI_MOVING_AVERAGE_CACHE_ASSERT_SVH
`ifndef SYNTH
// Checks that a condition holds at every clock edge outside reset.
`define KRMA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("krma check failed");
// Checks that a consequence holds in the cycle after its trigger.
`define KRMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("krma check failed");
`else
`define KRMA_ASSERT(lbl, cond)
`define KRMA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/krma_pkg.sv
package krma_pkg;

  // Fixed field widths of the stream payloads.
  localparam int KEY_W       = 48;
  localparam int TIME_W      = 32;
  localparam int SAMPLE_W    = 8;
  localparam int AVG_W       = 16;
  localparam int SLOT_OUT_W  = 4;
  localparam int COUNT_OUT_W = 4;
  localparam int FRAC_W      = 8;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 32;

  // Item kind carried on the input tuser bit.
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RING_RD,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: src/krma_div.sv
module krma_div #(
  parameter int DW = 20,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          neg,
  input  logic [DW-1:0] mag,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo
);
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] shreg;
  logic [VW:0]   rem;
  logic [VW-1:0] dvs;
  logic          sign;
  logic [VW:0]   rem_sh;
  logic          fits;

  // One quotient bit per cycle, restoring form on the magnitude.
  always_comb begin
    rem_sh = {rem[VW-1:0], shreg[DW-1]};
    fits   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(DW);
        shreg <= mag;
        rem   <= '0;
        dvs   <= divisor;
        sign  <= neg;
      end else if (busy) begin
        rem   <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        shreg <= {shreg[DW-2:0], fits};
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign goes back on after the magnitude divide: truncation toward zero.
  assign quo = sign ? (~shreg + 1'b1) : shreg;

endmodule

// File: src/keyed_rssi_moving_average_cache.sv
// Keyed moving average of signal strength. Each sample item (tuser low) looks up its
// 48-bit address in CACHE_SLOTS slots, takes a free slot or evicts the least recently
// seen one on a miss, pushes the sample into that device's window of AVG_WINDOW samples
// and returns sum*256/count as a signed Q8 value together with slot, new-entry flag and
// count. A clear item (tuser high) empties the cache at once and returns nothing.
// Items are handled one at a time. A sample item takes the slot scan through the slot
// memory, one entry per cycle and ending early on a hit, then a ring memory read and
// write-back, then a bit-serial divide of the scaled sum by the count, and then the
// handoff of the result to the output register.
// A new item is taken while the previous result still waits on the output.
`include "keyed_rssi_moving_average_cache_assert.svh"
module keyed_rssi_moving_average_cache #(
  parameter int CACHE_SLOTS = 16,
  parameter int AVG_WINDOW  = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // device_address [47:0], rssi_sample [55:48], now_time [87:56]
  input  logic [krma_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode [0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // average_q8 [15:0], slot_used [19:16], new_entry [20], sample_count [24:21], zero [31:25]
  output logic [krma_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import krma_pkg::*;

  localparam int SW    = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int CW    = SW + 1;
  localparam int NW    = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int FW    = $clog2(AVG_WINDOW + 1);
  localparam int SUMW  = SAMPLE_W + $clog2(AVG_WINDOW);
  localparam int DW    = SUMW + FRAC_W;
  localparam int RDEP  = CACHE_SLOTS * AVG_WINDOW;
  localparam int RAW   = (RDEP > 1) ? $clog2(RDEP) : 1;
  localparam int MW    = KEY_W + TIME_W + FW + NW + SUMW;
  localparam int O_NXT = SUMW;
  localparam int O_FIL = SUMW + NW;
  localparam int O_TIM = SUMW + NW + FW;
  localparam int O_KEY = SUMW + NW + FW + TIME_W;

  state_t state, state_next;

  // Slot memory: key, last-seen time, fill, next position and sum per slot.
  logic [MW-1:0]       meta_mem [CACHE_SLOTS];
  logic [MW-1:0]       meta_q;
  logic                meta_re;
  logic [SW-1:0]       meta_raddr;
  logic                meta_we;
  logic [MW-1:0]       meta_wdata;
  // Sample ring memory, one row of AVG_WINDOW entries per slot.
  logic [SAMPLE_W-1:0] ring_mem [RDEP];
  logic [SAMPLE_W-1:0] ring_q;

  logic [CACHE_SLOTS-1:0] slot_valid;

  logic [KEY_W-1:0]           key;
  logic signed [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]          now_t;
  logic [CW-1:0]              rd_cnt;
  logic                       ev_vld;
  logic [SW-1:0]              ev_idx;
  logic                       free_found;
  logic [SW-1:0]              free_idx;
  logic                       old_found;
  logic [SW-1:0]              old_idx;
  logic [TIME_W-1:0]          old_time;
  logic [SW-1:0]              sel;
  logic                       new_flag;
  logic [FW-1:0]              fill;
  logic [NW-1:0]              nxt;
  logic signed [SUMW-1:0]     sum;
  logic [RAW-1:0]             ring_addr;
  logic [FW-1:0]              out_count;
  logic                       count_ok;

  // Scan evaluation of the entry read in the previous cycle.
  logic              e_valid, e_match, hit_now, last_eval, scan_done;
  logic              free_n, old_take, old_n;
  logic [SW-1:0]     free_idx_n, old_idx_n, sel_n;
  logic              full;
  logic signed [SUMW-1:0] sum_n;
  logic [FW-1:0]     fill_n;
  logic [NW-1:0]     nxt_n;
  logic              in_xfer, out_xfer;
  logic              div_start, div_done;
  logic [DW-1:0]     div_mag, div_quo;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    e_valid    = slot_valid[ev_idx];
    e_match    = (meta_q[O_KEY +: KEY_W] == key);
    hit_now    = ev_vld && e_valid && e_match;
    last_eval  = ev_vld && (ev_idx == SW'(CACHE_SLOTS - 1));
    scan_done  = hit_now || last_eval;
    free_n     = free_found || (ev_vld && !e_valid);
    free_idx_n = free_found ? free_idx : ev_idx;
    old_take   = ev_vld && e_valid && !e_match &&
                 (!old_found || (meta_q[O_TIM +: TIME_W] < old_time));
    old_n      = old_found || old_take;
    old_idx_n  = old_take ? ev_idx : old_idx;
    sel_n      = hit_now ? ev_idx : (free_n ? free_idx_n : old_idx_n);
  end

  // Window update from the slot state and the displaced sample.
  always_comb begin
    full   = (fill == FW'(AVG_WINDOW));
    sum_n  = sum + SUMW'(sample) - (full ? SUMW'($signed(ring_q)) : SUMW'(0));
    fill_n = full ? fill : fill + 1'b1;
    nxt_n  = (nxt == NW'(AVG_WINDOW - 1)) ? NW'(0) : nxt + 1'b1;
    ring_addr = RAW'(sel) * RAW'(AVG_WINDOW) + RAW'(nxt);
    div_mag   = sum_n[SUMW-1] ? DW'(-sum_n) << FRAC_W : DW'(sum_n) << FRAC_W;
  end

  assign meta_re    = (state == ST_SCAN) && (rd_cnt < CW'(CACHE_SLOTS));
  assign meta_raddr = rd_cnt[SW-1:0];
  assign meta_we    = (state == ST_UPDATE);
  assign meta_wdata = {key, now_t, fill_n, nxt_n, sum_n};
  assign div_start  = (state == ST_UPDATE);
  assign count_ok   = (out_count != '0) && (out_count <= FW'(AVG_WINDOW));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && (s_tuser != MODE_CLEAR)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_next = ST_RING_RD;
      end
      ST_RING_RD: state_next = ST_UPDATE;
      ST_UPDATE:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Slot memory port.
  always_ff @(posedge clk) begin
    if (meta_re) meta_q <= meta_mem[meta_raddr];
    if (meta_we) meta_mem[sel] <= meta_wdata;
  end

  // Ring memory port: the oldest sample is read only once the window is full.
  always_ff @(posedge clk) begin
    if (state == ST_RING_RD && full) ring_q <= ring_mem[ring_addr];
    if (state == ST_UPDATE) ring_mem[ring_addr] <= sample;
  end

  // Valid bits, cleared at once by reset or a clear item.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (in_xfer && (s_tuser == MODE_CLEAR)) begin
      slot_valid <= '0;
    end else if (state == ST_UPDATE) begin
      slot_valid[sel] <= 1'b1;
    end
  end

  // Item capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_vld <= 1'b0;
    end else begin
      if (in_xfer) begin
        key        <= s_tdata[KEY_W-1:0];
        sample     <= s_tdata[KEY_W +: SAMPLE_W];
        now_t      <= s_tdata[KEY_W + SAMPLE_W +: TIME_W];
        rd_cnt     <= '0;
        ev_vld     <= 1'b0;
        free_found <= 1'b0;
        old_found  <= 1'b0;
      end else if (state == ST_SCAN) begin
        ev_vld     <= meta_re;
        ev_idx     <= meta_raddr;
        rd_cnt     <= meta_re ? rd_cnt + 1'b1 : rd_cnt;
        free_found <= free_n;
        free_idx   <= free_idx_n;
        old_found  <= old_n;
        old_idx    <= old_idx_n;
        if (old_take) old_time <= meta_q[O_TIM +: TIME_W];
        if (scan_done) begin
          ev_vld   <= 1'b0;
          sel      <= sel_n;
          new_flag <= !hit_now;
          fill     <= hit_now ? meta_q[O_FIL +: FW] : '0;
          nxt      <= hit_now ? meta_q[O_NXT +: NW] : '0;
          sum      <= hit_now ? $signed(meta_q[SUMW-1:0]) : '0;
        end
      end else if (state == ST_UPDATE) begin
        out_count <= fill_n;
      end
    end
  end

  krma_div #(
    .DW(DW),
    .VW(FW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .neg    (sum_n[SUMW-1]),
    .mag    (div_mag),
    .divisor(fill_n),
    .done   (div_done),
    .quo    (div_quo)
  );

  // Output register: loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'd0, COUNT_OUT_W'(out_count), new_flag, SLOT_OUT_W'(sel),
                     AVG_W'(div_quo)};
      end else if (out_xfer) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `KRMA_ASSERT_NEXT(a_clear_empties, in_xfer && (s_tuser == MODE_CLEAR), slot_valid == '0)
  `KRMA_ASSERT_NEXT(a_slot_taken, state == ST_UPDATE, slot_valid[sel])
  `KRMA_ASSERT(a_count_range, (state != ST_OUT) || count_ok)
  `KRMA_ASSERT(a_ready_idle, !s_tready || (state == ST_IDLE))

endmodule

// File: tb/sv/tb_keyed_rssi_moving_average_cache.sv
module tb_keyed_rssi_moving_average_cache;
  import krma_pkg::*;

  localparam int SLOTS  = 16;
  localparam int WINDOW = 10;

  // One predicted result of a sample transfer.
  typedef struct packed {
    logic signed [AVG_W-1:0]       average_q8;
    logic [SLOT_OUT_W-1:0]         slot_used;
    logic                          new_entry;
    logic [COUNT_OUT_W-1:0]        sample_count;
  } avg_result_t;

  // Tracks the cache contents and holds the averages still to come out.
  class rssi_cache_scoreboard;
    logic             valid[SLOTS];
    logic [KEY_W-1:0] key[SLOTS];
    logic [TIME_W-1:0] seen[SLOTS];
    logic signed [7:0] ring[SLOTS][WINDOW];
    int               fill[SLOTS];
    int               next_pos[SLOTS];
    int               sum[SLOTS];
    avg_result_t      pending[$];
    int               errors;

    function new();
      errors = 0;
      flush();
    endfunction

    function void flush();
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] = 1'b0; key[i] = '0; seen[i] = '0;
        fill[i] = 0; next_pos[i] = 0; sum[i] = 0;
      end
    endfunction

    // Note an accepted input transfer and predict its average.
    function void note_input(logic clear, logic [KEY_W-1:0] addr,
                             logic signed [7:0] rssi, logic [TIME_W-1:0] now);
      int hit, free_s, oldest, s, avg;
      avg_result_t r;
      hit = -1; free_s = -1; oldest = -1;
      if (clear == MODE_CLEAR) begin
        flush();
        return;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0) begin
          if (valid[i]) begin
            if (key[i] == addr) hit = i;
            else if (oldest < 0 || seen[i] < seen[oldest]) oldest = i;
          end else if (free_s < 0) begin
            free_s = i;
          end
        end
      end
      if (hit >= 0) begin
        s = hit;
      end else begin
        s = (free_s >= 0) ? free_s : oldest;
        valid[s] = 1'b1; key[s] = addr;
        fill[s] = 0; next_pos[s] = 0; sum[s] = 0;
      end
      seen[s] = now;
      if (fill[s] < WINDOW) begin
        sum[s] += rssi;
        fill[s]++;
      end else begin
        sum[s] += rssi - ring[s][next_pos[s]];
      end
      ring[s][next_pos[s]] = rssi;
      next_pos[s] = (next_pos[s] + 1) % WINDOW;
      avg = (sum[s] * 256) / fill[s];
      r.average_q8 = avg[15:0];
      r.slot_used = s[3:0];
      r.new_entry = (hit < 0);
      r.sample_count = fill[s][3:0];
      pending.push_back(r);
    endfunction

    // Compare one output transfer with the oldest prediction.
    function void check_result(logic [OUT_DATA_W-1:0] data);
      avg_result_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", data));
        return;
      end
      exp_r = pending.pop_front();
      if (data[15:0] !== exp_r.average_q8)
        report_mismatch($sformatf("average got %h want %h", data[15:0], exp_r.average_q8));
      if (data[19:16] !== exp_r.slot_used)
        report_mismatch($sformatf("slot got %0d want %0d", data[19:16], exp_r.slot_used));
      if (data[20] !== exp_r.new_entry)
        report_mismatch($sformatf("new_entry got %b want %b", data[20], exp_r.new_entry));
      if (data[24:21] !== exp_r.sample_count)
        report_mismatch($sformatf("count got %0d want %0d", data[24:21],
                                  exp_r.sample_count));
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic stim_done;

  rssi_cache_scoreboard sb;

  keyed_rssi_moving_average_cache dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Random gaps; some stretches run without any gap.
  function automatic int draw_gap(bit busy);
    return busy ? 0 : $urandom_range(0, 15);
  endfunction

  // Send one transfer and wait for its acceptance.
  task automatic send_item(logic clear, logic [KEY_W-1:0] addr,
                           logic [7:0] rssi, logic [TIME_W-1:0] now, bit busy);
    int gap;
    gap = draw_gap(busy);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= clear;
    s_tdata <= {now, rssi, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(clear, addr, rssi, now);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Output side: random stalls, checking every accepted result.
  logic burst_out;
  initial begin
    int gap;
    m_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = burst_out ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  logic [KEY_W-1:0] addr_pool[24];

  initial begin
    logic [TIME_W-1:0] tick;
    logic [KEY_W-1:0] a;
    bit busy;
    sb = new();
    burst_out = 0;
    rst = 1; s_tvalid = 0; s_tuser = 0; s_tdata = '0; stim_done = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes, window wrap, eviction with ties, clear.
    send_item(1'b0, '1, 8'h7f, '1, 1'b0);
    send_item(1'b0, '0, 8'h80, '0, 1'b0);
    for (int i = 0; i < 12; i++) send_item(1'b0, 48'h0, 8'h80, i, 1'b0);
    for (int i = 0; i < 14; i++) send_item(1'b0, 48'h1000 + i, 8'h7f, 32'd5, i[0]);
    send_item(1'b0, 48'hABCDEF, 8'hff, 32'd6, 1'b0);
    send_item(1'b1, '1, 8'h55, '1, 1'b0);
    send_item(1'b0, '1, 8'h01, 32'd0, 1'b0);

    // Hold the sender until the pipeline has drained.
    s_tvalid <= 0;
    @(negedge clk);
    wait_drained();

    // Random: mostly a small pool of devices so windows fill and slots churn.
    foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom(), $urandom()});
    tick = $urandom();
    for (int n = 0; n < 1350; n++) begin
      busy = (n % 200) < 30;
      burst_out = (n % 300) > 250;
      tick = tick + $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 85) a = addr_pool[$urandom_range(0, 23)];
      else a = 48'({$urandom(), $urandom()});
      if ($urandom_range(0, 149) == 0)
        send_item(1'b1, a, 8'($urandom()), $urandom(), busy);
      else
        send_item(1'b0, a, 8'($urandom()),
                  ($urandom_range(0, 9) == 0) ? $urandom() : tick, busy);
    end
    burst_out = 0;
    s_tvalid <= 0;
    @(negedge clk);
    wait_drained();
    repeat (100) @(negedge clk);
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: keyed_rssi_moving_average_cache.f
+incdir+src
src/krma_pkg.sv
src/krma_div.sv
src/keyed_rssi_moving_average_cache.sv
tb/sv/tb_keyed_rssi_moving_average_cache.sv
